FILE: design/glm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid local maximum marker package
// Shared constants, the flag record type and the beat kind enum used by the
// peak stage and the result emitter.
// ----------------------------------------------------------------------------
package glm_pkg;

  // Width of the row and column fields of a result beat.
  localparam int COORD_W = 5;

  // Width of the side configuration register.
  localparam int CFG_W = 6;

  // Side value after reset and the smallest side that is processed.
  localparam int CFG_SIDE_RESET = 32;
  localparam int MIN_SIDE = 3;

  // Defaults for the top-level parameters.
  localparam int MAX_SIDE_DEF = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // Record queue between the peak stage and the emitter.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One record per pixel that causes results: an optional flag for the
  // position up and to the left, an optional right-border flag for the
  // row above, and an optional flush of the whole last row.
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               peak;
    logic               main_v;
    logic               border_v;
    logic               flush;
  } glm_rec_t;

  // Which part of a record the emitter sends in a given cycle.
  typedef enum logic [1:0] {
    EMIT_MAIN,
    EMIT_BORDER,
    EMIT_FLUSH
  } glm_emit_e;

endpackage

FILE: design/grid_local_maximum_marker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid local maximum marker
// Marks 4-neighbor local maxima of a square frame streamed in raster order.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock and gives one flag beat per clock. The
// flag of a position leaves after the pixel one row below and one column to
// its right has been taken: each pixel reads its column of the line store in
// the cycle it is accepted and writes the column back in the next one, so a
// pixel uses the store's single read and single write port once each.
// Flags then pass a four-record queue and an output register on their way
// to the result port. Ties count as peaks and border
// positions are always 0. The last pixel of a side-s frame causes s+2 beats.
// These drain while the first row and the first pixel of the next row of the
// following frame stream in, and those pixels cause no beats. So while the
// result side takes every beat the input never stalls and the rate is one
// pixel per clock; the input stalls only once a result hold has filled the
// queue. A side write restarts the frame and must only be sent while no beat
// is in flight.
// ----------------------------------------------------------------------------
module grid_local_maximum_marker_unit #(
  parameter int MaxSide = glm_pkg::MAX_SIDE_DEF,
  parameter int SampleBits = glm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [glm_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SampleBits-1:0]  pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [glm_pkg::COORD_W-1:0]   row_o,
  output logic [glm_pkg::COORD_W-1:0]   col_o,
  output logic                          is_peak_o,
  output logic                          last_o
);
  import glm_pkg::*;

  localparam int IdxW = $clog2(MaxSide);

  logic                  cfg_wr;
  logic                  push;
  glm_rec_t              rec;
  logic [IdxW-1:0]       last_idx;
  logic [FIFO_CNT_W-1:0] fifo_level;

  // The side register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // Raster tracking, line store and peak test.
  glm_peak_stage #(
    .MaxSide   (MaxSide),
    .SampleBits(SampleBits)
  ) u_peak_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .fifo_level_i(fifo_level),
    .push_o      (push),
    .rec_o       (rec),
    .last_idx_o  (last_idx)
  );

  // Record queue and beat sequencing.
  glm_emitter #(
    .MaxSide(MaxSide)
  ) u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rec_i      (rec),
    .last_idx_i (last_idx),
    .level_o    (fifo_level),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .row_o      (row_o),
    .col_o      (col_o),
    .is_peak_o  (is_peak_o),
    .last_o     (last_o)
  );

  // The record queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_level <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("record queue overflow");

  // A record is never pushed into a full queue.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_level != FIFO_CNT_W'(FIFO_DEPTH)) || (out_valid_o && !out_stall_i))
    else $error("push into full record queue");

  // The final beat of a frame sits on the diagonal corner.
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> (row_o == col_o) && !is_peak_o)
    else $error("last beat away from the corner");

  // Border positions never carry a peak.
  a_border_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_peak_o |-> (row_o != '0) && (col_o != '0))
    else $error("peak flagged on the border");

endmodule

FILE: design/glm_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid local maximum marker line store
// Single-port-write, single-port-read synchronous memory holding the two most
// recent rows of samples, one column per entry. Read data is registered.
// ----------------------------------------------------------------------------
module glm_line_store #(
  parameter int Depth = 32,
  parameter int Width = 32,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/glm_peak_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid local maximum marker peak stage
// Follows the raster with row and column counters, reads and rewrites the
// line store once per pixel, and builds the flag record for each pixel.
// ----------------------------------------------------------------------------
module glm_peak_stage #(
  parameter int MaxSide = glm_pkg::MAX_SIDE_DEF,
  parameter int SampleBits = glm_pkg::SAMPLE_BITS_DEF,
  localparam int IdxW = $clog2(MaxSide)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_wr_i,
  input  logic [glm_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [SampleBits-1:0]     pixel_i,
  input  logic [glm_pkg::FIFO_CNT_W-1:0]   fifo_level_i,
  output logic                             push_o,
  output glm_pkg::glm_rec_t                rec_o,
  output logic [IdxW-1:0]                  last_idx_o
);
  import glm_pkg::*;

  localparam int ResetSide = (CFG_SIDE_RESET > MaxSide) ? MaxSide : CFG_SIDE_RESET;
  localparam int WideW = IdxW + COORD_W;

  logic                         acc;
  logic [IdxW-1:0]              last_idx_q, last_idx_d;
  logic [IdxW-1:0]              row_cnt_q, row_cnt_d;
  logic [IdxW-1:0]              col_cnt_q, col_cnt_d;
  logic                         p_valid_q;
  logic signed [SampleBits-1:0] p_pix_q;
  logic [IdxW-1:0]              p_row_q;
  logic [IdxW-1:0]              p_col_q;
  logic signed [SampleBits-1:0] prior1_q;
  logic signed [SampleBits-1:0] prior2_q;
  logic signed [SampleBits-1:0] up_q;
  logic signed [SampleBits-1:0] down_q;
  logic [2*SampleBits-1:0]      rd_data;
  logic signed [SampleBits-1:0] rd_older;
  logic signed [SampleBits-1:0] rd_prior;
  logic [IdxW-1:0]              row_m1;
  logic [IdxW-1:0]              col_m1;
  logic [WideW-1:0]             row_wide;
  logic [WideW-1:0]             col_wide;
  logic                         inner;
  logic                         beaten;
  logic                         main_v;
  logic                         border_v;

  // An item is taken only while the record queue has room for it and for
  // the record still in flight.
  assign in_stall_o = (fifo_level_i + FIFO_CNT_W'(p_valid_q)) >= FIFO_CNT_W'(FIFO_DEPTH);
  assign acc = in_valid_i && !in_stall_o;

  // Side register, kept as the index of the last row and column.
  always_comb begin
    last_idx_d = last_idx_q;
    if (cfg_wr_i) begin
      if (cfg_data_i < CFG_W'(MIN_SIDE)) begin
        last_idx_d = IdxW'(MIN_SIDE - 1);
      end else if (cfg_data_i > CFG_W'(MaxSide)) begin
        last_idx_d = IdxW'(MaxSide - 1);
      end else begin
        last_idx_d = IdxW'(cfg_data_i - CFG_W'(1));
      end
    end
  end

  // Raster counters; a side write restarts the frame.
  always_comb begin
    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    if (cfg_wr_i) begin
      row_cnt_d = '0;
      col_cnt_d = '0;
    end else if (acc) begin
      if (col_cnt_q == last_idx_q) begin
        col_cnt_d = '0;
        row_cnt_d = (row_cnt_q == last_idx_q) ? '0 : row_cnt_q + IdxW'(1);
      end else begin
        col_cnt_d = col_cnt_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_idx_q <= IdxW'(ResetSide - 1);
      row_cnt_q  <= '0;
      col_cnt_q  <= '0;
      p_valid_q  <= 1'b0;
    end else begin
      last_idx_q <= last_idx_d;
      row_cnt_q  <= row_cnt_d;
      col_cnt_q  <= col_cnt_d;
      p_valid_q  <= acc;
    end
  end

  // Pixel and position held for the cycle in which the line store answers.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      p_pix_q <= pixel_i;
      p_row_q <= row_cnt_q;
      p_col_q <= col_cnt_q;
    end
  end

  // Neighbor window: the two previous entries of the previous row, the entry
  // above the last column, and the previous pixel of this row.
  always_ff @(posedge clk_i) begin
    if (p_valid_q) begin
      prior1_q <= rd_prior;
      prior2_q <= prior1_q;
      up_q     <= rd_older;
      down_q   <= p_pix_q;
    end
  end

  // Each entry holds the older row in the upper half and the previous row
  // in the lower half; the rewrite shifts the column down by one row.
  glm_line_store #(
    .Depth(MaxSide),
    .Width(2 * SampleBits)
  ) u_line_store (
    .clk_i    (clk_i),
    .rd_en_i  (acc),
    .rd_addr_i(col_cnt_q),
    .rd_data_o(rd_data),
    .wr_en_i  (p_valid_q),
    .wr_addr_i(p_col_q),
    .wr_data_i({rd_prior, p_pix_q})
  );

  assign rd_older = rd_data[2*SampleBits-1:SampleBits];
  assign rd_prior = rd_data[SampleBits-1:0];

  // Peak test for the position one row up and one column left.
  assign inner = (p_row_q > IdxW'(1)) && (p_col_q > IdxW'(1));
  assign beaten = (prior2_q > prior1_q) || (rd_prior > prior1_q) ||
                  (up_q > prior1_q) || (down_q > prior1_q);

  assign main_v   = (p_row_q != '0) && (p_col_q != '0);
  assign border_v = (p_row_q != '0) && (p_col_q == last_idx_q);

  // Coordinates of the flagged position, cut to the output width.
  assign row_m1   = p_row_q - IdxW'(1);
  assign col_m1   = p_col_q - IdxW'(1);
  assign row_wide = {{COORD_W{1'b0}}, row_m1};
  assign col_wide = {{COORD_W{1'b0}}, col_m1};

  always_comb begin
    rec_o.row      = row_wide[COORD_W-1:0];
    rec_o.col      = col_wide[COORD_W-1:0];
    rec_o.peak     = inner && !beaten;
    rec_o.main_v   = main_v;
    rec_o.border_v = border_v;
    rec_o.flush    = (p_row_q == last_idx_q) && (p_col_q == last_idx_q);
  end

  assign push_o     = p_valid_q && (main_v || border_v);
  assign last_idx_o = last_idx_q;

endmodule

FILE: design/glm_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid local maximum marker result emitter
// Queues flag records and expands each into its result beats, one beat per
// cycle while the output is not stalled, through a registered output.
// ----------------------------------------------------------------------------
module glm_emitter #(
  parameter int MaxSide = glm_pkg::MAX_SIDE_DEF,
  localparam int IdxW = $clog2(MaxSide)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  glm_pkg::glm_rec_t               rec_i,
  input  logic [IdxW-1:0]                 last_idx_i,
  output logic [glm_pkg::FIFO_CNT_W-1:0]  level_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [glm_pkg::COORD_W-1:0]     row_o,
  output logic [glm_pkg::COORD_W-1:0]     col_o,
  output logic                            is_peak_o,
  output logic                            last_o
);
  import glm_pkg::*;

  localparam int WideW = IdxW + COORD_W;

  glm_rec_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_q;
  logic [FIFO_PTR_W-1:0]  rd_ptr_q;
  logic [FIFO_CNT_W-1:0]  count_q, count_d;
  glm_rec_t               head;
  logic                   main_done_q, main_done_d;
  logic                   border_done_q, border_done_d;
  logic [IdxW-1:0]        k_q, k_d;
  glm_emit_e              kind;
  logic                   load;
  logic                   pop;
  logic                   rec_end;
  logic [WideW-1:0]       last_wide;
  logic [WideW-1:0]       k_wide;
  logic                   out_valid_q, out_valid_d;
  logic [COORD_W-1:0]     beat_row;
  logic [COORD_W-1:0]     beat_col;
  logic                   beat_peak;
  logic                   beat_last;
  logic [COORD_W-1:0]     row_q;
  logic [COORD_W-1:0]     col_q;
  logic                   peak_q;
  logic                   last_q;

  assign head      = fifo_q[rd_ptr_q];
  assign last_wide = {{COORD_W{1'b0}}, last_idx_i};
  assign k_wide    = {{COORD_W{1'b0}}, k_q};

  // A new beat is loaded whenever a record waits and the output register is free or drains.
  assign load = (count_q != '0) && (!out_valid_q || !out_stall_i);
  assign pop  = load && rec_end;

  // Choose the next part of the head record.
  always_comb begin
    if (head.main_v && !main_done_q) begin
      kind = EMIT_MAIN;
    end else if (head.border_v && !border_done_q) begin
      kind = EMIT_BORDER;
    end else begin
      kind = EMIT_FLUSH;
    end
  end

  // Beat contents and whether the head record is finished with this beat.
  always_comb begin
    case (kind)
      EMIT_MAIN: begin
        beat_row  = head.row;
        beat_col  = head.col;
        beat_peak = head.peak;
        beat_last = 1'b0;
        rec_end   = !head.border_v && !head.flush;
      end
      EMIT_BORDER: begin
        beat_row  = head.row;
        beat_col  = last_wide[COORD_W-1:0];
        beat_peak = 1'b0;
        beat_last = 1'b0;
        rec_end   = !head.flush;
      end
      EMIT_FLUSH: begin
        beat_row  = last_wide[COORD_W-1:0];
        beat_col  = k_wide[COORD_W-1:0];
        beat_peak = 1'b0;
        beat_last = (k_q == last_idx_i);
        rec_end   = (k_q == last_idx_i);
      end
      default: begin
        beat_row  = '0;
        beat_col  = '0;
        beat_peak = 1'b0;
        beat_last = 1'b0;
        rec_end   = 1'b1;
      end
    endcase
  end

  // Progress through the head record.
  always_comb begin
    main_done_d   = main_done_q;
    border_done_d = border_done_q;
    k_d           = k_q;
    if (pop) begin
      main_done_d   = 1'b0;
      border_done_d = 1'b0;
      k_d           = '0;
    end else if (load) begin
      case (kind)
        EMIT_MAIN:   main_done_d   = 1'b1;
        EMIT_BORDER: border_done_d = 1'b1;
        EMIT_FLUSH:  k_d           = k_q + IdxW'(1);
        default:     k_d           = k_q;
      endcase
    end
  end

  // Queue fill level and output valid.
  assign count_d = count_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(pop);

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q      <= '0;
      rd_ptr_q      <= '0;
      count_q       <= '0;
      main_done_q   <= 1'b0;
      border_done_q <= 1'b0;
      k_q           <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      wr_ptr_q      <= push_i ? wr_ptr_q + FIFO_PTR_W'(1) : wr_ptr_q;
      rd_ptr_q      <= pop ? rd_ptr_q + FIFO_PTR_W'(1) : rd_ptr_q;
      count_q       <= count_d;
      main_done_q   <= main_done_d;
      border_done_q <= border_done_d;
      k_q           <= k_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Record storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= rec_i;
    end
  end

  // Output beat register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      row_q  <= beat_row;
      col_q  <= beat_col;
      peak_q <= beat_peak;
      last_q <= beat_last;
    end
  end

  assign level_o     = count_q;
  assign out_valid_o = out_valid_q;
  assign row_o       = row_q;
  assign col_o       = col_q;
  assign is_peak_o   = peak_q;
  assign last_o      = last_q;

endmodule

FILE: verif/tb_grid_local_maximum_marker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the grid local maximum marker unit
// Streams square frames of signed samples through the unit and compares each
// flag beat with a local model of the 4-neighbor peak marker. A few fixed
// frames cover the sample extremes and ties. Random frames follow, with
// varied sides, mid-frame restarts and random idle on both channels. One long
// hold on the result channel lets the unit fill up and stall its input.
// ----------------------------------------------------------------------------
module tb_grid_local_maximum_marker_unit;

  localparam int SB = glm_pkg::SAMPLE_BITS_DEF;
  localparam int MS = glm_pkg::MAX_SIDE_DEF;
  localparam int CW = glm_pkg::CFG_W;
  localparam int XW = glm_pkg::COORD_W;

  // Cycles allowed for the unit to settle after the last expected beat.
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 200;

  typedef struct packed {
    logic [XW-1:0] row;
    logic [XW-1:0] col;
    logic          peak;
    logic          last;
  } peak_flag_t;

  // Local model of the marker and the queue of flags it still owes.
  class peak_flag_scoreboard;
    int unsigned errors;
    int unsigned side_now;
    int unsigned row_n;
    int unsigned col_n;
    logic signed [SB-1:0] older_row [MS];
    logic signed [SB-1:0] prior_row [MS];
    logic signed [SB-1:0] left_px;
    logic signed [SB-1:0] up_px;
    peak_flag_t owed_flags [$];

    function new();
      errors = 0;
      side_now = glm_pkg::CFG_SIDE_RESET;
      row_n = 0;
      col_n = 0;
      left_px = '0;
      up_px = '0;
      foreach (older_row[i]) begin
        older_row[i] = '0;
        prior_row[i] = '0;
      end
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 30) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function int unsigned pending();
      return owed_flags.size();
    endfunction

    // A side write restarts the frame; out-of-range sides are clamped.
    function void load_side(input logic [CW-1:0] value);
      if (value < glm_pkg::MIN_SIDE) side_now = glm_pkg::MIN_SIDE;
      else if (value > MS) side_now = MS;
      else side_now = int'(value);
      row_n = 0;
      col_n = 0;
    endfunction

    function void add_flag(input int unsigned r, input int unsigned c,
                           input bit pk, input bit lst);
      peak_flag_t f;
      f.row = r[XW-1:0];
      f.col = c[XW-1:0];
      f.peak = pk;
      f.last = lst;
      owed_flags.push_back(f);
    endfunction

    // Works out the flags that one accepted sample causes.
    function void note_pixel(input logic signed [SB-1:0] px);
      int unsigned r;
      int unsigned c;
      logic signed [SB-1:0] centre;
      bit pk;
      r = row_n;
      c = col_n;
      if (r >= side_now || c >= side_now) begin
        r = 0;
        c = 0;
      end
      // Flag of the position one row up and one column left.
      if (r >= 1 && c >= 1) begin
        pk = 1'b0;
        if (r >= 2 && c >= 2) begin
          centre = older_row[c-1];
          pk = !(older_row[c-2] > centre || prior_row[c] > centre ||
                 up_px > centre || left_px > centre);
        end
        add_flag(r - 1, c - 1, pk, 1'b0);
      end
      // Right border of the row above.
      if (r >= 1 && c == side_now - 1) add_flag(r - 1, side_now - 1, 1'b0, 1'b0);
      up_px = older_row[c];
      older_row[c] = prior_row[c];
      prior_row[c] = px;
      left_px = px;
      // The last sample flushes the bottom border row.
      if (r == side_now - 1 && c == side_now - 1) begin
        for (int unsigned k = 0; k < side_now; k++)
          add_flag(side_now - 1, k, 1'b0, k == side_now - 1);
      end
      c++;
      if (c >= side_now) begin
        c = 0;
        r++;
        if (r >= side_now) r = 0;
      end
      row_n = r;
      col_n = c;
    endfunction

    task check_flag(input peak_flag_t got);
      peak_flag_t want;
      if (owed_flags.size() == 0) begin
        report($sformatf("unexpected flag row %0d col %0d peak %b last %b",
                         got.row, got.col, got.peak, got.last));
        return;
      end
      want = owed_flags.pop_front();
      if (got.row !== want.row || got.col !== want.col ||
          got.peak !== want.peak || got.last !== want.last)
        report($sformatf("flag row %0d col %0d peak %b last %b, want %0d %0d %b %b",
                         got.row, got.col, got.peak, got.last,
                         want.row, want.col, want.peak, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic signed [SB-1:0] pixel = '0;
  logic out_stall = 1'b0;

  logic cfg_ready;
  logic in_stall;
  logic out_valid;
  logic [XW-1:0] row_q;
  logic [XW-1:0] col_q;
  logic is_peak;
  logic last_q;

  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int unsigned sent_pixels = 0;
  peak_flag_scoreboard sb;

  // Fixed frames: a saturated peak with ties up and down, and a flat frame at
  // the most negative value where every inner position ties.
  logic signed [SB-1:0] peak_frame [9] = '{
    16'sh8000, 16'sh7FFF, 16'sh8000,
    16'shFFFF, 16'sh7FFF, 16'sh0000,
    16'sh0001, 16'sh7FFF, 16'sh8000};
  logic signed [SB-1:0] partial_frame [5] = '{
    16'sh0005, 16'sh0003, 16'sh0007, 16'sh0002, 16'sh0001};

  grid_local_maximum_marker_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .pixel_i     (pixel),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .row_o       (row_q),
    .col_o       (col_q),
    .is_peak_o   (is_peak),
    .last_o      (last_q)
  );

  always #10 clk = ~clk;

  // Check every accepted result beat against the oldest owed flag.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_flag({row_q, col_q, is_peak, last_q});
  end

  // Result channel stall pattern, including one long hold on request.
  initial begin : result_stall
    int unsigned span;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        span = LONG_HOLD;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        span = $urandom_range(1, 6);
        out_stall <= 1'b1;
      end else begin
        span = idle_on ? $urandom_range(1, 10) : 1;
        out_stall <= 1'b0;
      end
      repeat (span) @(posedge clk);
    end
  end

  // Sample generator: full range, small values for ties, extremes, plateaus.
  function automatic logic signed [SB-1:0] gen_pixel(input int unsigned style);
    int v;
    case (style)
      0: v = $urandom;
      1: v = int'($urandom_range(0, 6)) - 3;
      2: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          2: v = -1;
          default: v = 0;
        endcase
      end
      default: v = 1000 * int'($urandom_range(0, 2)) - 1000;
    endcase
    return v[SB-1:0];
  endfunction

  // Send one sample beat, with an occasional idle burst before it.
  task automatic send_pixel(input logic signed [SB-1:0] px);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(px);
    sent_pixels++;
  endtask

  // Write the side register once the unit has drained.
  task automatic write_side(input logic [CW-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.load_side(value);
  endtask

  // Set a side, send whole frames, then optionally a partial frame that the
  // next side write cuts off.
  task automatic run_frames(input logic [CW-1:0] cfg, input int unsigned frames,
                            input int unsigned tail_max, input bit with_hold);
    int unsigned area;
    int unsigned tail;
    int unsigned style;
    write_side(cfg);
    if (with_hold) hold_req = 1'b1;
    area = sb.side_now * sb.side_now;
    repeat (frames) begin
      style = $urandom_range(0, 3);
      repeat (area) send_pixel(gen_pixel(style));
    end
    if (tail_max >= 2) begin
      tail = $urandom_range(tail_max / 2, tail_max);
      if (tail > area - 1) tail = area - 1;
      repeat (tail) send_pixel(gen_pixel($urandom_range(0, 3)));
    end
  endtask

  initial begin : stimulus
    int unsigned base;
    int unsigned waited;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames; sides 0 and 2 both act as the smallest side.
    write_side(6'd0);
    foreach (peak_frame[i]) send_pixel(peak_frame[i]);
    write_side(6'd2);
    repeat (9) send_pixel(16'sh8000);
    // Partial frame, restarted by the next side write.
    write_side(6'd3);
    foreach (partial_frame[i]) send_pixel(partial_frame[i]);

    run_frames(6'd4, 2, 0, 1'b0);
    // Oversized side, clamped to the maximum, cut off within the second or third row.
    run_frames(6'd63, 0, 70, 1'b0);
    // One full frame under a long result hold.
    run_frames(6'd6, 1, 0, 1'b1);

    base = sent_pixels;
    while (sent_pixels - base < 150) begin
      if (sent_pixels - base > 100) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0: run_frames(CW'($urandom_range(0, 2)), $urandom_range(1, 3), 0, 1'b0);
        1: run_frames(CW'($urandom_range(9, 10)), 1, 0, 1'b0);
        2: run_frames(CW'($urandom_range(33, 62)), 0, 40, 1'b0);
        3: run_frames(CW'($urandom_range(3, 8)), $urandom_range(0, 1), 20, 1'b0);
        default: run_frames(CW'($urandom_range(3, 8)), $urandom_range(1, 2), 0, 1'b0);
      endcase
    end

    // Drain, then leave time for any stray beats.
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected flags never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit.
  initial begin : watchdog
    #(10_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
design/glm_pkg.sv
design/glm_line_store.sv
design/glm_peak_stage.sv
design/glm_emitter.sv
design/grid_local_maximum_marker_unit.sv
verif/tb_grid_local_maximum_marker_unit.sv
